FILE: src/svpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and helpers for the SVPWM sector/duty core.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int D_W = 38;

  localparam logic signed [18:0] SQRT3_Q16 = 19'sd113512;

  localparam logic [15:0] PERIOD_RESET = 16'd8500;
  localparam logic [15:0] LIMIT_RESET  = 16'd4250;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'd1;

  localparam logic [2:0] CODE_U1  = 3'd1;
  localparam logic [2:0] CODE_U2  = 3'd2;
  localparam logic [2:0] CODE_U12 = 3'd3;
  localparam logic [2:0] CODE_U3  = 3'd4;
  localparam logic [2:0] CODE_U13 = 3'd5;
  localparam logic [2:0] CODE_U23 = 3'd6;

  localparam logic [1:0] PHASE_LAST = 2'd2;
  localparam logic [2:0] DIV_LAST   = 3'd7;

  typedef logic signed [D_W-1:0] dval_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DSEL,
    ST_SUM,
    ST_MUL,
    ST_COMB,
    ST_DIV,
    ST_STORE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       dsel;
    logic       sum;
    logic       mul;
    logic       comb;
    logic       div;
    logic       store;
    logic       out_load;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic [2:0] sector_of(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      CODE_U1:  s = 3'd2;
      CODE_U2:  s = 3'd6;
      CODE_U12: s = 3'd1;
      CODE_U3:  s = 3'd4;
      CODE_U13: s = 3'd3;
      CODE_U23: s = 3'd5;
      default:  s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: src/svpwm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_ctrl
// Sequencer: steps the datapath through setup, then three phases of
// multiply, overflow check, radix-4 division and store, then the output load.
// ----------------------------------------------------------------------------
module svpwm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  svpwm_pkg::status_t status,
  output svpwm_pkg::cmd_t    cmd
);

  svpwm_pkg::state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svpwm_pkg::ST_IDLE;
      phase_r <= 2'd0;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.phase = phase_r;
    in_ready  = 1'b0;
    case (state_r)
      svpwm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = svpwm_pkg::ST_PREP;
        end
      end
      svpwm_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = svpwm_pkg::ST_DSEL;
      end
      svpwm_pkg::ST_DSEL: begin
        cmd.dsel  = 1'b1;
        state_nxt = svpwm_pkg::ST_SUM;
      end
      svpwm_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        phase_nxt = 2'd0;
        state_nxt = svpwm_pkg::ST_MUL;
      end
      svpwm_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = svpwm_pkg::ST_COMB;
      end
      svpwm_pkg::ST_COMB: begin
        cmd.comb  = 1'b1;
        cnt_nxt   = 3'd0;
        state_nxt = svpwm_pkg::ST_DIV;
      end
      svpwm_pkg::ST_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == svpwm_pkg::DIV_LAST) begin
          state_nxt = svpwm_pkg::ST_STORE;
        end
      end
      svpwm_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        if (phase_r == svpwm_pkg::PHASE_LAST) begin
          state_nxt = svpwm_pkg::ST_FIN;
        end else begin
          phase_nxt = phase_r + 2'd1;
          state_nxt = svpwm_pkg::ST_MUL;
        end
      end
      svpwm_pkg::ST_FIN: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = svpwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = svpwm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/svpwm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_dp
// Datapath: config registers, axis projection and sector code, active-time
// terms, per-phase multiply and divide by bus voltage, clamp, output register.
// ----------------------------------------------------------------------------
module svpwm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  svpwm_pkg::cmd_t                      cmd,
  output svpwm_pkg::status_t                   status,
  input  logic signed [15:0]                   in_v_alpha,
  input  logic signed [15:0]                   in_v_beta,
  input  logic [15:0]                          in_bus_voltage,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [15:0]                          out_compare_a,
  output logic [15:0]                          out_compare_b,
  output logic [15:0]                          out_compare_c,
  output logic [2:0]                           out_sector,
  input  logic                                 cfg_we,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                          cfg_wdata
);

  logic [15:0] period_r, limit_r;
  logic [2:0]  last_sec_r;
  logic        out_valid_r;

  logic signed [15:0] va_r, vb_r;
  logic [15:0]        bus_r;

  svpwm_pkg::dval_t g_r, h_r, dx_r, dy_r;
  logic [2:0]       code_r, sec_r;
  logic [2:0]       neg_x_r, neg_y_r;
  svpwm_pkg::dval_t s_r [3];

  logic [33:0] pp_lo_r, pp_hi_r;
  logic        pos_r, sat_r;
  logic [15:0] rem_r, dvd_r, q_r;
  logic [15:0] res_r [3];

  logic [15:0] oa_r, ob_r, oc_r;
  logic [2:0]  osec_r;

  // projection and sign code
  logic signed [33:0]   a_prod, g_prod;
  svpwm_pkg::dval_t     va_x, vb_x, a_x, u2, u3, h_nxt;
  logic [2:0]           code_nxt;

  always_comb begin
    a_prod = 34'(va_r) * 34'(svpwm_pkg::SQRT3_Q16);
    g_prod = 34'(vb_r) * 34'(svpwm_pkg::SQRT3_Q16);
    va_x   = svpwm_pkg::dval_t'(va_r);
    vb_x   = svpwm_pkg::dval_t'(vb_r);
    a_x    = svpwm_pkg::dval_t'(a_prod);
    u2     = a_x - (vb_x <<< 16);
    u3     = -a_x - (vb_x <<< 16);
    h_nxt  = (va_x <<< 17) + (va_x <<< 16);
    code_nxt[0] = !vb_r[15] && (vb_r != 16'sd0);
    code_nxt[1] = !u2[svpwm_pkg::D_W-1] && (u2 != '0);
    code_nxt[2] = !u3[svpwm_pkg::D_W-1] && (u3 != '0);
  end

  // active-time terms and sign selection per phase
  svpwm_pkg::dval_t g2, dx_nxt, dy_nxt;
  logic [2:0]       nx_nxt, ny_nxt;
  logic             zero_code;

  always_comb begin
    g2        = g_r <<< 1;
    dx_nxt    = '0;
    dy_nxt    = '0;
    nx_nxt    = 3'b000;
    ny_nxt    = 3'b000;
    zero_code = 1'b0;
    case (code_r)
      svpwm_pkg::CODE_U1: begin
        dx_nxt = g_r - h_r;    dy_nxt = h_r + g_r;
        nx_nxt = 3'b101;       ny_nxt = 3'b100;
      end
      svpwm_pkg::CODE_U2: begin
        dx_nxt = h_r + g_r;    dy_nxt = -g2;
        nx_nxt = 3'b110;       ny_nxt = 3'b010;
      end
      svpwm_pkg::CODE_U12: begin
        dx_nxt = h_r - g_r;    dy_nxt = g2;
        nx_nxt = 3'b110;       ny_nxt = 3'b100;
      end
      svpwm_pkg::CODE_U3: begin
        dx_nxt = -g2;          dy_nxt = g_r - h_r;
        nx_nxt = 3'b011;       ny_nxt = 3'b001;
      end
      svpwm_pkg::CODE_U13: begin
        dx_nxt = g2;           dy_nxt = -(h_r + g_r);
        nx_nxt = 3'b101;       ny_nxt = 3'b001;
      end
      svpwm_pkg::CODE_U23: begin
        dx_nxt = -(h_r + g_r); dy_nxt = h_r - g_r;
        nx_nxt = 3'b011;       ny_nxt = 3'b010;
      end
      default: begin
        zero_code = 1'b1;
      end
    endcase
  end

  // s = 2^17*bus + d for each phase
  svpwm_pkg::dval_t bias, t_v [3], s_nxt [3];

  always_comb begin
    bias = svpwm_pkg::dval_t'({bus_r, 17'd0});
    for (int i = 0; i < 3; i++) begin
      t_v[i]   = neg_x_r[i] ? (bias - dx_r) : (bias + dx_r);
      s_nxt[i] = neg_y_r[i] ? (t_v[i] - dy_r) : (t_v[i] + dy_r);
    end
  end

  // multiply, overflow check, radix-4 division step
  svpwm_pkg::dval_t s_sel;
  logic [35:0]      s_u;
  logic             pos_nxt;
  logic [51:0]      prod;
  logic [16:0]      n_hi;
  logic [16:0]      r1, r2;
  logic [15:0]      rem1, rem2;
  logic             qb1, qb2;
  logic [15:0]      res_nxt;

  always_comb begin
    s_sel   = s_r[cmd.phase];
    s_u     = s_sel[35:0];
    pos_nxt = !s_sel[svpwm_pkg::D_W-1] && (s_sel != '0) && (period_r != 16'd0);
    prod    = {pp_hi_r, 18'd0} + {18'd0, pp_lo_r};
    n_hi    = prod[51:35];

    r1   = {rem_r, dvd_r[15]};
    qb1  = (r1 >= {1'b0, bus_r});
    rem1 = qb1 ? 16'(r1 - {1'b0, bus_r}) : r1[15:0];
    r2   = {rem1, dvd_r[14]};
    qb2  = (r2 >= {1'b0, bus_r});
    rem2 = qb2 ? 16'(r2 - {1'b0, bus_r}) : r2[15:0];

    if (!pos_r) begin
      res_nxt = 16'd0;
    end else if (sat_r || (q_r > limit_r)) begin
      res_nxt = limit_r;
    end else begin
      res_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= svpwm_pkg::PERIOD_RESET;
      limit_r     <= svpwm_pkg::LIMIT_RESET;
      last_sec_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          svpwm_pkg::REG_PERIOD: period_r <= cfg_wdata;
          svpwm_pkg::REG_LIMIT:  limit_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        last_sec_r  <= sec_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r  <= in_v_alpha;
      vb_r  <= in_v_beta;
      bus_r <= (in_bus_voltage == 16'd0) ? 16'd1 : in_bus_voltage;
    end
    if (cmd.prep) begin
      g_r    <= svpwm_pkg::dval_t'(g_prod);
      h_r    <= h_nxt;
      code_r <= code_nxt;
    end
    if (cmd.dsel) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      neg_x_r <= nx_nxt;
      neg_y_r <= ny_nxt;
      sec_r   <= zero_code ? last_sec_r : svpwm_pkg::sector_of(code_r);
    end
    if (cmd.sum) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= s_nxt[i];
      end
    end
    if (cmd.mul) begin
      pp_lo_r <= 34'(period_r) * 34'(s_u[17:0]);
      pp_hi_r <= 34'(period_r) * 34'(s_u[35:18]);
      pos_r   <= pos_nxt;
    end
    if (cmd.comb) begin
      sat_r <= (n_hi >= {1'b0, bus_r});
      rem_r <= n_hi[15:0];
      dvd_r <= prod[34:19];
      q_r   <= 16'd0;
    end
    if (cmd.div) begin
      rem_r <= rem2;
      dvd_r <= {dvd_r[13:0], 2'b00};
      q_r   <= {q_r[13:0], qb1, qb2};
    end
    if (cmd.store) begin
      res_r[cmd.phase] <= res_nxt;
    end
    if (cmd.out_load) begin
      oa_r   <= res_r[0];
      ob_r   <= res_r[1];
      oc_r   <= res_r[2];
      osec_r <= sec_r;
    end
  end

  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_compare_a   = oa_r;
  assign out_compare_b   = ob_r;
  assign out_compare_c   = oc_r;
  assign out_sector      = osec_r;

endmodule

FILE: src/svpwm_sector_duty_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_sector_duty_core
// Space-vector PWM by the sector method: one alpha/beta vector and bus
// voltage in, three clamped compare counts and the sector out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes v_alpha, v_beta and bus_voltage
//   as one item. Result channel (out_valid/out_ready) returns compare_a/b/c
//   and sector, one result item per input item, in order.
//   cfg_we/cfg_index/cfg_wdata write period_counts (index 0) and
//   compare_limit (index 1); write them only while the core is idle.
//   The core takes no new item until the current result has been loaded
//   into the output register. The three phases share one
//   multiply-and-divide unit; each phase runs the multiply, overflow check,
//   two-bit-per-cycle division by bus voltage, then clamp and store.
//   in_ready is high whenever the core is idle, also while a finished result
//   waits in the output register. If the receiver stalls, the next result
//   holds inside the core until the output register frees.
//   Reset: period_counts = 8500, compare_limit = 4250, held sector = 0,
//   no result pending.
// ----------------------------------------------------------------------------
module svpwm_sector_duty_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_v_alpha,
  input  logic signed [15:0]               in_v_beta,
  input  logic [15:0]                      in_bus_voltage,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      out_compare_a,
  output logic [15:0]                      out_compare_b,
  output logic [15:0]                      out_compare_c,
  output logic [2:0]                       out_sector,
  input  logic                             cfg_we,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                      cfg_wdata
);

  svpwm_pkg::cmd_t    cmd;
  svpwm_pkg::status_t status;

  svpwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  svpwm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_v_alpha     (in_v_alpha),
    .in_v_beta      (in_v_beta),
    .in_bus_voltage (in_bus_voltage),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_compare_a  (out_compare_a),
    .out_compare_b  (out_compare_b),
    .out_compare_c  (out_compare_c),
    .out_sector     (out_sector),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

endmodule
